// ===== rtl/core/mrf_pkg.sv =====
package mrf_pkg;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_UNEXPECTED  = 2'd2
    } t_status;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT    = 8'd4;
    localparam logic [7:0] FC_WRITE_SINGLE  = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [8:0] WRITE_RESP_LEN = 9'd8;
    localparam logic [8:0] READ_RESP_BASE = 9'd5;

    localparam int CMD_BYTES = 7;

    typedef struct packed {
        logic [CMD_BYTES-1:0][7:0] bytes;
        logic [2:0]                nbytes;
        logic                      add_crc;
        logic                      crc_init;
        logic                      err;
        logic [8:0]                exp_len;
        t_status                   status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrf_front.sv =====
module mrf_front
    import mrf_pkg::*;
#(
    parameter int MAX_WORDS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_full,
    input  logic        i_func,
    input  logic [7:0]  i_slave_id,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_start_address,
    input  logic [5:0]  i_word_count,
    input  logic [31:0] i_data_value,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_data,
    output logic        o_cfg_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [5:0] MaxWords = 6'(MAX_WORDS);

    logic       r_wide_mode;
    logic [5:0] r_words;
    logic [5:0] n_words;
    logic [8:0] r_held;
    logic [8:0] n_held;

    logic [5:0] words_c;
    logic [6:0] regs;
    logic [7:0] regs2;
    logic [8:0] read_len;

    assign o_cfg_ready = 1'b1;
    assign o_push      = i_valid && !i_full;

    assign words_c  = (i_word_count > MaxWords) ? MaxWords : i_word_count;
    assign regs     = r_wide_mode ? {words_c, 1'b0} : {1'b0, words_c};
    assign regs2    = {regs, 1'b0};
    assign read_len = READ_RESP_BASE + {1'b0, regs2};

    always_comb begin
        n_words  = r_words;
        n_held   = r_held;
        o_cmd    = '0;
        o_cmd.status = ST_OK;
        if (i_func == KIND_DATA) begin
            o_cmd.exp_len = r_held;
            if (r_words == 6'd0) begin
                o_cmd.nbytes = 3'd1;
                o_cmd.err    = 1'b1;
                o_cmd.status = ST_UNEXPECTED;
            end else begin
                o_cmd.bytes[0] = i_data_value[15:8];
                o_cmd.bytes[1] = i_data_value[7:0];
                o_cmd.bytes[2] = i_data_value[31:24];
                o_cmd.bytes[3] = i_data_value[23:16];
                o_cmd.nbytes   = 3'd4;
                o_cmd.add_crc  = (r_words == 6'd1);
                n_words        = r_words - 6'd1;
            end
        end else begin
            n_words        = 6'd0;
            o_cmd.bytes[0] = i_slave_id;
            o_cmd.bytes[1] = i_function_code;
            o_cmd.bytes[2] = i_start_address[15:8];
            o_cmd.bytes[3] = i_start_address[7:0];
            o_cmd.crc_init = 1'b1;
            unique case (i_function_code) inside
                FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
                    n_held         = read_len;
                    o_cmd.exp_len  = read_len;
                    o_cmd.bytes[4] = 8'h00;
                    o_cmd.bytes[5] = {1'b0, regs};
                    o_cmd.nbytes   = 3'd6;
                    o_cmd.add_crc  = 1'b1;
                end
                FC_WRITE_SINGLE: begin
                    n_held         = WRITE_RESP_LEN;
                    o_cmd.exp_len  = WRITE_RESP_LEN;
                    o_cmd.bytes[4] = i_data_value[15:8];
                    o_cmd.bytes[5] = i_data_value[7:0];
                    o_cmd.nbytes   = 3'd6;
                    o_cmd.add_crc  = 1'b1;
                end
                FC_WRITE_MULTI: begin
                    n_held         = WRITE_RESP_LEN;
                    o_cmd.exp_len  = WRITE_RESP_LEN;
                    o_cmd.bytes[4] = 8'h00;
                    o_cmd.bytes[5] = {1'b0, regs};
                    o_cmd.bytes[6] = regs2;
                    o_cmd.nbytes   = 3'd7;
                    o_cmd.add_crc  = (words_c == 6'd0);
                    n_words        = words_c;
                end
                default: begin
                    o_cmd          = '0;
                    o_cmd.nbytes   = 3'd1;
                    o_cmd.err      = 1'b1;
                    o_cmd.status   = ST_UNSUPPORTED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
            r_words     <= 6'd0;
            r_held      <= 9'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wide_mode <= i_cfg_data;
            end
            if (o_push) begin
                r_words <= n_words;
                r_held  <= n_held;
            end
        end
    end

endmodule

// ===== rtl/core/mrf_queue.sv =====
module mrf_queue
    import mrf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output t_cmd   o_head,
    output t_qstat o_stat
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_head       = r_mem[r_rptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/mrf_back.sv =====
module mrf_back
    import mrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_byte,
    output logic       o_last_byte,
    output logic [8:0] o_expected_length,
    output logic [1:0] o_status
);

    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [8:0]  r_len;
    t_status     r_status;
    logic [3:0]  r_pos;
    logic [15:0] r_crc;

    logic        advance;
    logic        fire;
    logic [3:0]  total;
    logic        final_pos;
    logic        payload;
    logic [7:0]  sel_byte;
    logic [15:0] crc_base;

    assign advance   = !r_valid || !i_stall;
    assign fire      = advance && i_head_valid;
    assign total     = {1'b0, i_head.nbytes} + (i_head.add_crc ? 4'd2 : 4'd0);
    assign final_pos = (r_pos == total - 4'd1);
    assign payload   = (r_pos < {1'b0, i_head.nbytes});
    assign o_pop     = fire && final_pos;
    assign crc_base  = (r_pos == 4'd0 && i_head.crc_init) ? CRC_INIT : r_crc;

    always_comb begin
        if (payload) begin
            sel_byte = i_head.bytes[r_pos[2:0]];
        end else if (r_pos == {1'b0, i_head.nbytes}) begin
            sel_byte = r_crc[7:0];
        end else begin
            sel_byte = r_crc[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_byte   <= sel_byte;
            r_last   <= final_pos && (i_head.add_crc || i_head.err);
            r_len    <= i_head.exp_len;
            r_status <= i_head.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
            r_crc   <= CRC_INIT;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_pos   <= final_pos ? 4'd0 : r_pos + 4'd1;
                if (payload && !i_head.err) begin
                    r_crc <= crc16_byte(crc_base, sel_byte);
                end else if (final_pos && i_head.add_crc) begin
                    r_crc <= CRC_INIT;
                end
            end else if (advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_frame_byte      = r_byte;
    assign o_last_byte       = r_last;
    assign o_expected_length = r_len;
    assign o_status          = r_status;

endmodule

// ===== rtl/core/modbus_rtu_request_framer.sv =====
// Modbus RTU request framer. Input transactions on i_valid/o_stall carry either a
// request header or one data word for a write-multiple request. Output transactions
// on o_valid/i_stall carry one frame byte each, with the expected response length
// and a status; the last CRC byte and every error result have last_byte set.
// The wide_mode register is written through i_cfg_valid/o_cfg_ready/i_cfg_data and
// should only change while no request is in flight.
// Each accepted input is classified by the front end into a byte command and placed
// in a two-entry queue, so input is taken while earlier frames are still leaving.
// The first output byte of a transaction passes a queue entry and the output register.
// Bytes then leave at one per cycle from the output serializer while i_stall is low:
// a read or write-single header gives 8 bytes, a write-multiple header 7 (9 with zero
// words), a data word 4 (6 when it carries the CRC), an error a single byte.
// When the receiver stalls, the output byte holds, the queue fills, and o_stall
// rises once both queue entries are taken. Reset empties the queue and the output
// register, clears wide_mode and any pending write-multiple frame.
module modbus_rtu_request_framer
    import mrf_pkg::*;
#(
    parameter int MAX_WORDS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_slave_id,
    input  logic [7:0]  i_function_code,
    input  logic [15:0] i_start_address,
    input  logic [5:0]  i_word_count,
    input  logic [31:0] i_data_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last_byte,
    output logic [8:0]  o_expected_length,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat q_stat;
    logic   push;
    logic   pop;

    assign o_stall = q_stat.full;

    mrf_front #(
        .MAX_WORDS(MAX_WORDS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_full         (q_stat.full),
        .i_func         (i_func),
        .i_slave_id     (i_slave_id),
        .i_function_code(i_function_code),
        .i_start_address(i_start_address),
        .i_word_count   (i_word_count),
        .i_data_value   (i_data_value),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    mrf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_head (head_cmd),
        .o_stat (q_stat)
    );

    mrf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (!q_stat.empty),
        .i_head           (head_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_byte     (o_frame_byte),
        .o_last_byte      (o_last_byte),
        .o_expected_length(o_expected_length),
        .o_status         (o_status)
    );

    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> o_last_byte)
        else $error("error result without last_byte");

    a_unsupported_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_UNSUPPORTED) |-> (o_expected_length == 9'd0 &&
            o_frame_byte == 8'd0))
        else $error("unsupported code result carries nonzero fields");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

endmodule

// ===== tb/modbus_rtu_request_framer_tb.sv =====
module modbus_rtu_request_framer_tb;
    import mrf_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic        func;
        logic [7:0]  sid;
        logic [7:0]  code;
        logic [15:0] addr;
        logic [5:0]  words;
        logic [31:0] val;
    } t_req;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       last;
        logic [8:0] exp_len;
        t_status    st;
    } t_byte_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_func = 1'b0;
    logic [7:0]  i_slave_id = '0;
    logic [7:0]  i_function_code = '0;
    logic [15:0] i_start_address = '0;
    logic [5:0]  i_word_count = '0;
    logic [31:0] i_data_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_frame_byte;
    logic        o_last_byte;
    logic [8:0]  o_expected_length;
    logic [1:0]  o_status;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;

    t_req      req_pending[$];
    t_byte_res bytes_due[$];

    logic        wide_cfg = 1'b0;
    logic [15:0] crc_acc = CRC_INIT;
    logic [5:0]  words_left = '0;
    logic [8:0]  held_len = '0;

    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  in_acc = 0;
    bit  out_acc = 0;
    int  in_pause = 0;
    int  out_hold = 0;
    bit  in_burst = 0;
    bit  out_burst = 0;

    modbus_rtu_request_framer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_slave_id       (i_slave_id),
        .i_function_code  (i_function_code),
        .i_start_address  (i_start_address),
        .i_word_count     (i_word_count),
        .i_data_value     (i_data_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_frame_byte     (o_frame_byte),
        .o_last_byte      (o_last_byte),
        .o_expected_length(o_expected_length),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ b[k];
            r = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last,
                                      input logic [8:0] len, input t_status st);
        t_byte_res r;
        r.fbyte = b;
        r.last = last;
        r.exp_len = len;
        r.st = st;
        bytes_due.push_back(r);
    endfunction

    function automatic void emit_data(input logic [7:0] b);
        crc_acc = crc_next(crc_acc, b);
        push_byte(b, 1'b0, held_len, ST_OK);
    endfunction

    function automatic void emit_crc();
        push_byte(crc_acc[7:0], 1'b0, held_len, ST_OK);
        push_byte(crc_acc[15:8], 1'b1, held_len, ST_OK);
        crc_acc = CRC_INIT;
    endfunction

    function automatic void predict_frame_bytes(input t_req r);
        logic [15:0] regs;
        if (r.func == KIND_DATA) begin
            if (words_left == 0) begin
                push_byte(8'h00, 1'b1, held_len, ST_UNEXPECTED);
                return;
            end
            emit_data(r.val[15:8]);
            emit_data(r.val[7:0]);
            emit_data(r.val[31:24]);
            emit_data(r.val[23:16]);
            words_left = words_left - 6'd1;
            if (words_left == 0) begin
                emit_crc();
            end
            return;
        end
        words_left = '0;
        crc_acc = CRC_INIT;
        regs = wide_cfg ? 16'(r.words) * 16'd2 : 16'(r.words);
        if (r.code >= FC_READ_COILS && r.code <= FC_READ_INPUT) begin
            held_len = 9'(READ_RESP_BASE + regs * 2);
        end else if (r.code == FC_WRITE_SINGLE || r.code == FC_WRITE_MULTI) begin
            held_len = WRITE_RESP_LEN;
        end else begin
            push_byte(8'h00, 1'b1, 9'd0, ST_UNSUPPORTED);
            return;
        end
        emit_data(r.sid);
        emit_data(r.code);
        emit_data(r.addr[15:8]);
        emit_data(r.addr[7:0]);
        if (r.code == FC_WRITE_SINGLE) begin
            emit_data(r.val[15:8]);
            emit_data(r.val[7:0]);
            emit_crc();
        end else if (r.code == FC_WRITE_MULTI) begin
            emit_data(regs[15:8]);
            emit_data(regs[7:0]);
            emit_data(8'(regs * 2));
            words_left = r.words;
            if (words_left == 0) begin
                emit_crc();
            end
        end else begin
            emit_data(regs[15:8]);
            emit_data(regs[7:0]);
            emit_crc();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_byte_res want;
        t_req      r;
        bit        cfg_acc;
        in_acc = 0;
        out_acc = 0;
        cfg_acc = 0;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                out_acc = 1;
                if (bytes_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte %0h",
                             $time, o_frame_byte);
                    mismatches++;
                end else begin
                    want = bytes_due.pop_front();
                    check_field("frame_byte", want.fbyte, o_frame_byte);
                    check_field("last_byte", want.last, o_last_byte);
                    check_field("expected_length", want.exp_len, o_expected_length);
                    check_field("status", want.st, o_status);
                end
            end
            if (i_valid && !o_stall) begin
                in_acc = 1;
                r = '{i_func, i_slave_id, i_function_code, i_start_address,
                      i_word_count, i_data_value};
                predict_frame_bytes(r);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_acc = 1;
                wide_cfg = i_cfg_data;
            end
        end
        if (in_acc || out_acc || cfg_acc) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_acc) begin
        end else if (in_pause > 0) begin
            i_valid <= 1'b0;
            in_pause--;
        end else if (req_pending.size() != 0) begin
            r = req_pending.pop_front();
            i_func <= r.func;
            i_slave_id <= r.sid;
            i_function_code <= r.code;
            i_start_address <= r.addr;
            i_word_count <= r.words;
            i_data_value <= r.val;
            i_valid <= 1'b1;
            if ($urandom_range(0, 63) == 0) begin
                in_burst = !in_burst;
            end
            in_pause = in_burst ? 0 : $urandom_range(0, 7);
        end else begin
            i_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (out_acc) begin
            if ($urandom_range(0, 63) == 0) begin
                out_burst = !out_burst;
            end
            out_hold = out_burst ? 0 : $urandom_range(0, 7);
        end
        if (out_hold > 0) begin
            i_stall <= 1'b1;
            out_hold--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic queue_header(input logic [7:0] code, input logic [7:0] sid,
                                input logic [15:0] addr, input logic [5:0] words,
                                input logic [31:0] val);
        req_pending.push_back('{KIND_HEADER, sid, code, addr, words, val});
    endtask

    task automatic queue_data(input logic [31:0] val);
        req_pending.push_back('{KIND_DATA, 8'($urandom), 8'($urandom), 16'($urandom),
                                6'($urandom), val});
    endtask

    task automatic settle();
        do begin
            @(posedge i_clk);
        end while (req_pending.size() != 0 || i_valid || bytes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(input int n);
        int          count;
        int          pick;
        int          nw;
        int          nsend;
        logic [7:0]  code;
        count = 0;
        while (count < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                nw = ($urandom_range(0, 29) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
                nsend = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nw) : nw;
                queue_header(FC_WRITE_MULTI, 8'($urandom), 16'($urandom), 6'(nw), $urandom);
                for (int k = 0; k < nsend; k++) begin
                    queue_data($urandom);
                end
                count += 1 + nsend;
            end else if (pick < 68) begin
                queue_header(8'($urandom_range(1, 4)), 8'($urandom), 16'($urandom),
                             6'($urandom), $urandom);
                count++;
            end else if (pick < 82) begin
                queue_header(FC_WRITE_SINGLE, 8'($urandom), 16'($urandom),
                             6'($urandom), $urandom);
                count++;
            end else if (pick < 92) begin
                do begin
                    code = 8'($urandom);
                end while ((code >= FC_READ_COILS && code <= FC_READ_INPUT) ||
                           code == FC_WRITE_SINGLE || code == FC_WRITE_MULTI);
                queue_header(code, 8'($urandom), 16'($urandom), 6'($urandom), $urandom);
                count++;
            end else begin
                queue_data($urandom);
                count++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(1'b0);
        queue_header(FC_READ_COILS, 8'h00, 16'h0000, 6'd0, 32'h0000_0000);
        queue_header(FC_READ_DISCRETE, 8'hFF, 16'hFFFF, 6'd63, 32'hFFFF_FFFF);
        queue_header(FC_READ_HOLDING, 8'h01, 16'h1234, 6'd10, 32'h0);
        queue_header(FC_READ_INPUT, 8'h7F, 16'h8000, 6'd1, 32'h0);
        queue_header(FC_WRITE_SINGLE, 8'h11, 16'h0001, 6'd0, 32'h0000_FFFF);
        queue_header(FC_WRITE_SINGLE, 8'hA5, 16'hABCD, 6'd63, 32'hFFFF_0000);
        queue_header(8'h00, 8'h01, 16'h0000, 6'd1, 32'h0);
        queue_header(8'hFF, 8'h01, 16'hFFFF, 6'd1, 32'h0);
        queue_header(8'h05, 8'h01, 16'h0100, 6'd1, 32'h0);
        queue_data(32'hDEAD_BEEF);
        queue_header(FC_WRITE_MULTI, 8'h22, 16'h0010, 6'd0, 32'h0);
        queue_header(FC_WRITE_MULTI, 8'h23, 16'h0020, 6'd2, 32'h0);
        queue_data(32'h0000_0000);
        queue_data(32'hFFFF_FFFF);
        queue_header(FC_WRITE_MULTI, 8'h24, 16'h0030, 6'd3, 32'h0);
        queue_data(32'h1234_5678);
        queue_header(FC_READ_HOLDING, 8'h25, 16'h0040, 6'd2, 32'h0);
        queue_header(FC_WRITE_MULTI, 8'h26, 16'h0050, 6'd2, 32'h0);
        queue_data(32'h8765_4321);
        queue_header(8'h07, 8'h26, 16'h0050, 6'd2, 32'h0);
        queue_data(32'h5555_AAAA);
        req_pending.push_back('{KIND_DATA, 8'hFF, 8'hFF, 16'hFFFF, 6'd63, 32'h0});
        settle();

        cfg_write(1'b1);
        random_requests(140);
        settle();

        cfg_write(1'b0);
        random_requests(140);
        settle();

        cfg_write(1'b1);
        random_requests(140);
        settle();

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
